@@ design/cosm_pkg.sv @@
package cosm_pkg;

  localparam int ELEM_W  = 16;
  localparam int ACC_W   = 48;
  localparam int SCORE_W = 16;

  // Running sums handed from the accumulator to the score solver
  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic        [ACC_W-1:0] norm_a;
    logic        [ACC_W-1:0] norm_b;
  } sums_t;

  typedef struct packed {
    logic idle;
    logic done;
  } solve_stat_t;

endpackage

@@ design/cosm_sub.sv @@
module cosm_sub (
  input  logic [48:0] x,
  input  logic [48:0] y,
  output logic [48:0] diff,
  output logic        ge
);

  logic [49:0] wide;

  assign wide = {1'b0, x} - {1'b0, y};
  assign diff = wide[48:0];
  assign ge   = ~wide[49];

endmodule

@@ design/cosm_accum.sv @@
module cosm_accum (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  take,
  input  logic signed [cosm_pkg::ELEM_W-1:0]    elem_a,
  input  logic signed [cosm_pkg::ELEM_W-1:0]    elem_b,
  input  logic                                  last_elem,
  output logic                                  start,
  output cosm_pkg::sums_t                       sums
);

  localparam int PW = 2 * cosm_pkg::ELEM_W;
  localparam int AW = cosm_pkg::ACC_W;

  logic signed [PW-1:0] prod_ab, prod_aa, prod_bb;
  logic                 v1_r, last1_r;
  logic signed [PW-1:0] pd_r;
  logic [PW-2:0]        pa_r, pb_r;

  logic signed [AW-1:0] dot_r;
  logic [AW-1:0]        na_r, nb_r;
  logic signed [AW:0]   dot_wide;
  logic [AW:0]          na_wide, nb_wide;
  logic signed [AW-1:0] dot_sat;
  logic [AW-1:0]        na_sat, nb_sat;

  assign prod_ab = elem_a * elem_b;
  assign prod_aa = elem_a * elem_a;
  assign prod_bb = elem_b * elem_b;

  // Stage 1: register the three products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
    end else begin
      v1_r    <= take;
      last1_r <= take & last_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pd_r <= prod_ab;
      pa_r <= prod_aa[PW-2:0];
      pb_r <= prod_bb[PW-2:0];
    end
  end

  // Stage 2: saturating accumulate
  assign dot_wide = {dot_r[AW-1], dot_r} + (AW+1)'(pd_r);
  assign na_wide  = {1'b0, na_r} + (AW+1)'(pa_r);
  assign nb_wide  = {1'b0, nb_r} + (AW+1)'(pb_r);

  always_comb begin
    if (dot_wide[AW] != dot_wide[AW-1]) begin
      dot_sat = dot_wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      dot_sat = dot_wide[AW-1:0];
    end
    na_sat = na_wide[AW] ? {AW{1'b1}} : na_wide[AW-1:0];
    nb_sat = nb_wide[AW] ? {AW{1'b1}} : nb_wide[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
    end else if (v1_r) begin
      // clear after the last beat, its sums go to the solver
      if (last1_r) begin
        dot_r <= '0;
        na_r  <= '0;
        nb_r  <= '0;
      end else begin
        dot_r <= dot_sat;
        na_r  <= na_sat;
        nb_r  <= nb_sat;
      end
    end
  end

  assign start       = v1_r & last1_r;
  assign sums.dot    = dot_sat;
  assign sums.norm_a = na_sat;
  assign sums.norm_b = nb_sat;

endmodule

@@ design/cosm_solver.sv @@
module cosm_solver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  cosm_pkg::sums_t                     sums,
  input  logic                                take_result,
  output cosm_pkg::solve_stat_t               stat,
  output logic signed [cosm_pkg::SCORE_W-1:0] score
);

  localparam int AW  = cosm_pkg::ACC_W;
  localparam int SW  = AW / 2;
  localparam int QW  = cosm_pkg::SCORE_W - 1;
  localparam int CW  = $clog2(QW);
  localparam logic [AW-2:0] BIT_TOP = {1'b1, {(AW-2){1'b0}}};
  localparam logic signed [cosm_pkg::SCORE_W-1:0] SCORE_MAX = {1'b0, {QW{1'b1}}};
  localparam logic signed [cosm_pkg::SCORE_W-1:0] SCORE_MIN = {1'b1, {QW{1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQA  = 7'b0000010,
    S_SQB  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic            neg_r;
  logic [AW-1:0]   mag_r, nb_r, res_r, den_r;
  logic [AW:0]     rem_r;
  logic [AW-2:0]   bit_r;
  logic [SW-1:0]   sqa_r;
  logic [QW-1:0]   q_r;
  logic [CW-1:0]   cnt_r;
  logic signed [cosm_pkg::SCORE_W-1:0] score_r;

  logic [AW:0]     sub_x, sub_y, sub_diff;
  logic            sub_ge;
  logic [AW-1:0]   res_step;
  logic [QW-1:0]   q_step;
  logic [SW-1:0]   sqb;
  logic            sqrt_last;

  cosm_sub u_sub (
    .x    (sub_x),
    .y    (sub_y),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  // Operand select for the shared subtractor
  always_comb begin
    unique case (state_r)
      S_CHK: begin
        sub_x = {1'b0, mag_r};
        sub_y = {1'b0, den_r};
      end
      S_DIV: begin
        sub_x = {rem_r[AW-1:0], 1'b0};
        sub_y = {1'b0, den_r};
      end
      default: begin
        sub_x = rem_r;
        sub_y = {1'b0, res_r} + {2'b0, bit_r};
      end
    endcase
  end

  assign res_step  = sub_ge ? ({1'b0, res_r[AW-1:1]} + {1'b0, bit_r})
                            : {1'b0, res_r[AW-1:1]};
  assign q_step    = {q_r[QW-2:0], sub_ge};
  assign sqb       = res_r[SW-1:0];
  assign sqrt_last = bit_r[0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_SQA;
      S_SQA:  if (sqrt_last) state_nxt = S_SQB;
      S_SQB:  if (sqrt_last) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CHK;
      S_CHK:  state_nxt = (den_r == '0 || sub_ge) ? S_DONE : S_DIV;
      S_DIV:  if (cnt_r == '0) state_nxt = S_DONE;
      S_DONE: if (take_result) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_r <= sums.dot[AW-1];
          mag_r <= sums.dot[AW-1] ? AW'(-sums.dot) : AW'(sums.dot);
          nb_r  <= sums.norm_b;
          rem_r <= {1'b0, sums.norm_a};
          res_r <= '0;
          bit_r <= BIT_TOP;
        end
      end
      S_SQA: begin
        if (sqrt_last) begin
          // hold root of norm a, restart on norm b
          sqa_r <= res_step[SW-1:0];
          rem_r <= {1'b0, nb_r};
          res_r <= '0;
          bit_r <= BIT_TOP;
        end else begin
          rem_r <= sub_ge ? sub_diff : rem_r;
          res_r <= res_step;
          bit_r <= bit_r >> 2;
        end
      end
      S_SQB: begin
        rem_r <= sub_ge ? sub_diff : rem_r;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
      end
      S_MUL: begin
        den_r <= sqa_r * sqb;
      end
      S_CHK: begin
        if (den_r == '0) begin
          score_r <= '0;
        end else if (sub_ge) begin
          // quotient would reach one: clamp
          score_r <= neg_r ? SCORE_MIN : SCORE_MAX;
        end else begin
          rem_r <= {1'b0, mag_r};
          q_r   <= '0;
          cnt_r <= CW'(QW - 1);
        end
      end
      S_DIV: begin
        rem_r <= sub_ge ? sub_diff : {rem_r[AW-1:0], 1'b0};
        q_r   <= q_step;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          score_r <= neg_r ? -$signed({1'b0, q_step}) : $signed({1'b0, q_step});
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign score     = score_r;

endmodule

@@ design/cosine_similarity_match.sv @@
// Cosine similarity matcher. Element pairs of two signed Q1.15 vectors stream in
// at one beat per cycle while in_stall is low; the block keeps saturating 48-bit
// sums of a*b, a*a and b*b. The beat flagged last closes the vector: the block then
// stalls its input while one shared subtractor works out the two integer square
// roots (24 steps each), a 24x24 multiply forms the denominator, and a 15-step
// restoring divide gives the score, clamped to Q1.15 and zero when a norm is zero.
// A score that clamps or is zero skips the divide. A finished score that finds the
// output register full and stalled holds the input off until that register drains.
// The result beat carries the score and a flag set when it is at least the
// programmed threshold (reset 0.5). The next vector may stream in while a result
// waits on the output register.
module cosine_similarity_match (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cosm_pkg::ELEM_W-1:0]  in_elem_a,
  input  logic signed [cosm_pkg::ELEM_W-1:0]  in_elem_b,
  input  logic                                in_last_elem,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_match,
  output logic signed [cosm_pkg::SCORE_W-1:0] out_score,
  input  logic                                cfg_wr_en,
  input  logic signed [cosm_pkg::SCORE_W-1:0] cfg_wr_data
);

  localparam logic signed [cosm_pkg::SCORE_W-1:0] THR_RESET = 16'sd16384;

  logic                  take, start, load;
  cosm_pkg::sums_t       sums;
  cosm_pkg::solve_stat_t stat;
  logic signed [cosm_pkg::SCORE_W-1:0] score, thr_r, score_r;
  logic                  out_valid_r, match_r;

  assign in_stall = start | ~stat.idle;
  assign take     = in_valid & ~in_stall;

  cosm_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .elem_a    (in_elem_a),
    .elem_b    (in_elem_b),
    .last_elem (in_last_elem),
    .start     (start),
    .sums      (sums)
  );

  cosm_solver u_solver (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .sums        (sums),
    .take_result (load),
    .stat        (stat),
    .score       (score)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Output register: load when empty or being drained
  assign load = stat.done & (~out_valid_r | ~out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      score_r <= score;
      match_r <= (score >= thr_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_score    = score_r;
  assign out_is_match = match_r;

endmodule
